>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, checked outside reset
`define AST_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked outside reset
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/atc_pkg.sv
`default_nettype none
package atc_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int FRAC_BITS  = 9;
    localparam int X_W        = 8;
    localparam int SUM_W      = 16;
    localparam int FAC_W      = 10;
    localparam int INIT_W     = 11;
    localparam int LUMA_W     = 8;
    localparam int CFG_W      = 9;
    localparam int ACC_W      = 24;
    localparam int CNT_W      = 17;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int DIV_STEPS  = 24;

    // register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SENS   = 2'd2;

    localparam logic [8:0]  WIDTH_MIN  = 9'd16;
    localparam logic [8:0]  WIDTH_MAX  = 9'd256;
    localparam logic [8:0]  HEIGHT_MAX = 9'd256;
    localparam logic [6:0]  SENS_MAX   = 7'd100;
    localparam logic [12:0] RECIP_100  = 13'd5243;  // 2^19 / 100, rounded up
    localparam logic [9:0]  FRAC_ONE   = 10'd512;
    localparam logic [6:0]  INIT_LUMA  = 7'd127;

    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        logic [X_W-1:0]    x;
        logic [X_W-1:0]    y;
        logic              last;
        logic              first;
        logic [FAC_W-1:0]  q;
        logic [FAC_W-1:0]  f;
        logic [INIT_W-1:0] init;
    } t_cmd;

    // 512 / s for window sizes 1..16
    function automatic logic [9:0] one_over_s(input logic [4:0] s);
        logic [9:0] r;
        case (s)
            5'd1:    r = 10'd512;
            5'd2:    r = 10'd256;
            5'd3:    r = 10'd170;
            5'd4:    r = 10'd128;
            5'd5:    r = 10'd102;
            5'd6:    r = 10'd85;
            5'd7:    r = 10'd73;
            5'd8:    r = 10'd64;
            5'd9:    r = 10'd56;
            5'd10:   r = 10'd51;
            5'd11:   r = 10'd46;
            5'd12:   r = 10'd42;
            5'd13:   r = 10'd39;
            5'd14:   r = 10'd36;
            5'd15:   r = 10'd34;
            5'd16:   r = 10'd32;
            default: r = 10'd512;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

>>> rtl/adaptive_threshold_centroid.sv
`default_nettype none
// Adaptive threshold with dark-pixel centroid. Pixels arrive in serpentine order
// (even rows left to right, odd rows right to left); each gives one result with
// its coordinates and a bright/dark flag, and the last pixel of a frame also
// carries the mean coordinates of the dark pixels. Registers are latched on the
// first pixel of a frame. The back end takes one pixel at a time: it reads the pixel
// from the queue and the line store, then evaluates it (running-sum multiply/add
// and threshold), and output stall can hold it; the front end queues up to 4
// requests ahead. The first pixel of a frame waits for the scale-factor divide,
// and the last pixel for the centroid divide.
module adaptive_threshold_centroid import atc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [LUMA_W-1:0] i_luma,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [X_W-1:0]         o_pixel_x,
    output logic [X_W-1:0]         o_pixel_y,
    output logic                   o_bright,
    output logic                   o_frame_last,
    output logic [X_W-1:0]         o_dark_mean_x,
    output logic [X_W-1:0]         o_dark_mean_y,
    output logic                   o_centroid_valid
);
    t_cmd             push_cmd, pop_cmd;
    logic             push, pop, full, empty;
    logic             div_start, div_busy;
    logic [ACC_W-1:0] div_dvd, div_quot;
    logic [CNT_W-1:0] div_dsr;

    atc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_luma         (i_luma),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_cmd          (push_cmd),
        .i_full         (full),
        .o_div_start    (div_start),
        .o_div_dividend (div_dvd),
        .o_div_divisor  (div_dsr),
        .i_div_busy     (div_busy),
        .i_div_quot     (div_quot)
    );

    atc_div u_div_f (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_busy     (div_busy),
        .o_quotient (div_quot)
    );

    atc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_empty (empty)
    );

    atc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .o_pop            (pop),
        .i_cmd            (pop_cmd),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_pixel_x        (o_pixel_x),
        .o_pixel_y        (o_pixel_y),
        .o_bright         (o_bright),
        .o_frame_last     (o_frame_last),
        .o_dark_mean_x    (o_dark_mean_x),
        .o_dark_mean_y    (o_dark_mean_y),
        .o_centroid_valid (o_centroid_valid)
    );
endmodule
`default_nettype wire

>>> rtl/atc_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module atc_div import atc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [ACC_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic [ACC_W-1:0]      o_quotient
);
    logic             r_busy;
    logic [4:0]       r_cnt;
    logic [ACC_W-1:0] r_dvd;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_dsr;
    logic [CNT_W:0]   n_sh;
    logic             n_bit;

    always_comb begin
        n_sh  = {r_rem, r_dvd[ACC_W-1]};
        n_bit = (n_sh >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd0) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[ACC_W-2:0], n_bit};
            r_rem <= n_bit ? CNT_W'(n_sh - {1'b0, r_dsr}) : n_sh[CNT_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_dvd;
endmodule
`default_nettype wire

>>> rtl/atc_fifo.sv
`default_nettype none
`include "assert_macros.svh"
// short command queue between front and back
module atc_fifo import atc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_data,
    output logic      o_empty
);
    t_cmd               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) mem[r_wp] <= i_data;
    end

    assign o_data  = mem[r_rp];
    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);

    `AST_IMPL(a_fifo_bound, i_clk, i_rst_n, 1'b1, r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
    `AST_IMPL(a_fifo_no_underrun, i_clk, i_rst_n, i_pop, !o_empty)
endmodule
`default_nettype wire

>>> rtl/atc_front.sv
`default_nettype none
// front: config, frame setup, scan position, command issue
module atc_front import atc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_valid,
    input  wire logic [LUMA_W-1:0] i_luma,
    output logic                   o_stall,
    output logic                   o_push,
    output t_cmd                   o_cmd,
    input  wire logic              i_full,
    output logic                   o_div_start,
    output logic [ACC_W-1:0]       o_div_dividend,
    output logic [CNT_W-1:0]       o_div_divisor,
    input  wire logic              i_div_busy,
    input  wire logic [ACC_W-1:0]  i_div_quot
);
    localparam logic [1:0] F_RUN   = 2'd0;
    localparam logic [1:0] F_START = 2'd1;
    localparam logic [1:0] F_WAIT  = 2'd2;

    logic [8:0]        r_cfg_w, r_cfg_h;
    logic [6:0]        r_cfg_t;
    logic [1:0]        r_state;
    logic              r_fs, r_first;
    logic [8:0]        r_w, r_h;
    logic [4:0]        r_s;
    logic [FAC_W-1:0]  r_a, r_q, r_f;
    logic [INIT_W-1:0] r_init;
    logic [X_W-1:0]    r_x, r_y;

    logic [8:0]  n_w, n_h;
    logic [6:0]  n_t, n_u;
    logic [4:0]  n_s;
    logic [28:0] n_ap;
    logic        n_acc, n_row_end, n_last;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 9'd100;
            r_cfg_h <= 9'd100;
            r_cfg_t <= 7'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                CFG_SENS:   r_cfg_t <= i_cfg_data[6:0];
                default:    ;
            endcase
        end
    end

    // saturated frame settings and numerator 512*(100-t)/100
    always_comb begin
        n_w  = (r_cfg_w < WIDTH_MIN) ? WIDTH_MIN : ((r_cfg_w > WIDTH_MAX) ? WIDTH_MAX : r_cfg_w);
        n_h  = (r_cfg_h == 9'd0) ? 9'd1 : ((r_cfg_h > HEIGHT_MAX) ? HEIGHT_MAX : r_cfg_h);
        n_t  = (r_cfg_t > SENS_MAX) ? SENS_MAX : r_cfg_t;
        n_u  = SENS_MAX - n_t;
        n_s  = n_w[8:4];
        n_ap = 29'({n_u, 9'b0}) * 29'(RECIP_100);
    end

    // scan position
    always_comb begin
        n_acc     = (r_state == F_RUN) && !r_fs && i_valid && !i_full;
        n_row_end = r_y[0] ? (r_x == '0) : ({1'b0, r_x} == 9'(r_w - 9'd1));
        n_last    = n_row_end && ((9'({1'b0, r_y}) + 9'd1) >= r_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_RUN;
            r_fs    <= 1'b1;
            r_first <= 1'b0;
            r_x     <= '0;
            r_y     <= '0;
        end else begin
            case (r_state)
                F_RUN: begin
                    if (r_fs && i_valid) begin
                        r_state <= F_START;
                    end else if (n_acc) begin
                        r_first <= 1'b0;
                        if (n_last) begin
                            r_fs <= 1'b1;
                        end else if (n_row_end) begin
                            r_y <= r_y + 1'b1;
                        end else if (!r_y[0]) begin
                            r_x <= r_x + 1'b1;
                        end else begin
                            r_x <= r_x - 1'b1;
                        end
                    end
                end
                F_START: r_state <= F_WAIT;
                F_WAIT: begin
                    if (!i_div_busy) begin
                        r_state <= F_RUN;
                        r_fs    <= 1'b0;
                        r_first <= 1'b1;
                        r_x     <= '0;
                        r_y     <= '0;
                    end
                end
                default: r_state <= F_RUN;
            endcase
        end
    end

    // frame parameters, latched at frame start
    always_ff @(posedge i_clk) begin
        if (r_state == F_RUN && r_fs && i_valid) begin
            r_w    <= n_w;
            r_h    <= n_h;
            r_s    <= n_s;
            r_a    <= n_ap[28:19];
            r_q    <= FRAC_ONE - one_over_s(n_s);
            r_init <= INIT_W'(INIT_W'(INIT_LUMA) * INIT_W'(n_s));
        end
        if (r_state == F_WAIT && !i_div_busy) r_f <= i_div_quot[FAC_W-1:0];
    end

    assign o_div_start    = (r_state == F_START);
    assign o_div_dividend = ACC_W'(r_a);
    assign o_div_divisor  = CNT_W'(r_s);

    assign o_stall    = !((r_state == F_RUN) && !r_fs && !i_full);
    assign o_push     = n_acc;
    assign o_cmd.luma = i_luma;
    assign o_cmd.x    = r_x;
    assign o_cmd.y    = r_y;
    assign o_cmd.last = n_last;
    assign o_cmd.first = r_first;
    assign o_cmd.q    = r_q;
    assign o_cmd.f    = r_f;
    assign o_cmd.init = r_init;
endmodule
`default_nettype wire

>>> rtl/atc_back.sv
`default_nettype none
`include "assert_macros.svh"
// back: running sum, line store, threshold, centroid
module atc_back import atc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_empty,
    output logic             o_pop,
    input  wire t_cmd        i_cmd,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [X_W-1:0]   o_pixel_x,
    output logic [X_W-1:0]   o_pixel_y,
    output logic             o_bright,
    output logic             o_frame_last,
    output logic [X_W-1:0]   o_dark_mean_x,
    output logic [X_W-1:0]   o_dark_mean_y,
    output logic             o_centroid_valid
);
    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_EVAL = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;

    logic [SUM_W-1:0]     mem [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] r_vld;
    logic [1:0]           r_state;
    t_cmd                 r_cmd;
    logic [25:0]          r_prod;
    logic [SUM_W-1:0]     r_rd, r_rs;
    logic                 r_rdv, r_dark, r_cv;
    logic [ACC_W-1:0]     r_sx, r_sy;
    logic [CNT_W-1:0]     r_cnt;

    logic [SUM_W-1:0] n_rs_src, n_g, n_above, n_avg;
    logic [17:0]      n_gs;
    logic [25:0]      n_thp;
    logic             n_dark, n_free, n_commit, n_out, n_set;
    logic [ACC_W-1:0] n_sx, n_sy, q_x, q_y;
    logic [CNT_W-1:0] n_cnt;
    logic             busy_x, busy_y;

    // running sum update and threshold
    always_comb begin
        n_rs_src = i_cmd.first ? SUM_W'(i_cmd.init) : r_rs;
        n_gs     = 18'(r_prod[25:FRAC_BITS]) + 18'(r_cmd.luma);
        n_g      = (n_gs[17:16] != 2'b00) ? 16'hFFFF : n_gs[15:0];
        n_above  = r_rdv ? r_rd : SUM_W'(r_cmd.init);
        n_avg    = SUM_W'((17'(n_g) + 17'(n_above)) >> 1);
        n_thp    = 26'(n_avg) * 26'(r_cmd.f);
        n_dark   = 17'(r_cmd.luma) < n_thp[25:FRAC_BITS];
        n_sx     = n_dark ? r_sx + ACC_W'(r_cmd.x) : r_sx;
        n_sy     = n_dark ? r_sy + ACC_W'(r_cmd.y) : r_sy;
        n_cnt    = n_dark ? r_cnt + 1'b1 : r_cnt;
        n_free   = !o_valid || !i_stall;
        o_pop    = (r_state == B_IDLE) && !i_empty;
        n_commit = (r_state == B_EVAL) && (r_cmd.last || n_free);
        n_out    = (r_state == B_DIV) && !busy_x && !busy_y && n_free;
        n_set    = (n_commit && !r_cmd.last) || n_out;
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (n_commit) mem[r_cmd.x] <= n_g;
        if (o_pop)    r_rd <= mem[i_cmd.x];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= i_cmd;
            r_prod <= 26'(n_rs_src) * 26'(i_cmd.q);
            r_rdv  <= !i_cmd.first && r_vld[i_cmd.x];
        end
        if (n_commit) begin
            r_rs   <= n_g;
            r_dark <= n_dark;
            r_cv   <= (n_cnt != '0);
        end
    end

    // control, accumulators, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_vld   <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (n_set) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_state <= B_EVAL;
                        if (i_cmd.first) r_vld <= '0;
                    end
                end
                B_EVAL: begin
                    if (n_commit) begin
                        r_vld[r_cmd.x] <= 1'b1;
                        if (r_cmd.last) begin
                            r_state <= B_DIV;
                            r_sx    <= '0;
                            r_sy    <= '0;
                            r_cnt   <= '0;
                        end else begin
                            r_state <= B_IDLE;
                            r_sx    <= n_sx;
                            r_sy    <= n_sy;
                            r_cnt   <= n_cnt;
                        end
                    end
                end
                B_DIV: begin
                    if (n_out) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (n_commit && !r_cmd.last) begin
            o_pixel_x        <= r_cmd.x;
            o_pixel_y        <= r_cmd.y;
            o_bright         <= !n_dark;
            o_frame_last     <= 1'b0;
            o_dark_mean_x    <= '0;
            o_dark_mean_y    <= '0;
            o_centroid_valid <= 1'b0;
        end else if (n_out) begin
            o_pixel_x        <= r_cmd.x;
            o_pixel_y        <= r_cmd.y;
            o_bright         <= !r_dark;
            o_frame_last     <= 1'b1;
            o_dark_mean_x    <= r_cv ? q_x[X_W-1:0] : '0;
            o_dark_mean_y    <= r_cv ? q_y[X_W-1:0] : '0;
            o_centroid_valid <= r_cv;
        end
    end

    atc_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_commit && r_cmd.last),
        .i_dividend (n_sx),
        .i_divisor  (n_cnt),
        .o_busy     (busy_x),
        .o_quotient (q_x)
    );

    atc_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_commit && r_cmd.last),
        .i_dividend (n_sy),
        .i_divisor  (n_cnt),
        .o_busy     (busy_y),
        .o_quotient (q_y)
    );

    `AST_IMPL(a_div_on_last, i_clk, i_rst_n, r_state == B_DIV, r_cmd.last)
    `AST_NEXT(a_pop_eval, i_clk, i_rst_n, o_pop, r_state == B_EVAL)
    `AST_IMPL(a_cv_last, i_clk, i_rst_n, o_valid && o_centroid_valid, o_frame_last)
endmodule
`default_nettype wire
